// ===== sv/ajb_pkg.sv =====
// Shared types, constants and codes of the audio jitter buffer.
`default_nettype none
package ajb_pkg;

  localparam int unsigned MaxFramesDefault  = 64;
  localparam int unsigned MaxSamplesDefault = 64;
  localparam int unsigned PopLimit          = 64;
  localparam int unsigned CountW            = 7;
  localparam int unsigned SeqW              = 16;
  localparam int unsigned FlagW             = 8;
  localparam int unsigned SampleW           = 16;
  localparam int unsigned DepthW            = 5;
  localparam logic [DepthW-1:0] DepthReset  = 5'd4;

  // kind codes on the input stream
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // register index on the configuration port
  localparam logic REG_TARGET_DEPTH = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [SeqW-1:0]      seq;
    logic [FlagW-1:0]     flag;
    logic [SampleW-1:0]   sample;
    logic                 last;
    logic [CountW-1:0]    cnt;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/ajb_front.sv =====
// Front end: decode the incoming transfer into a queue item.
`default_nettype none
module ajb_front
  import ajb_pkg::*;
(
  input  wire logic [1:0]         kind_i,
  input  wire logic [SeqW-1:0]    seq_i,
  input  wire logic [FlagW-1:0]   flag_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               last_i,
  input  wire logic [CountW-1:0]  out_count_i,
  output item_t                   item_o,
  output logic                    keep_o
);

  always_comb begin
    item_o.seq    = seq_i;
    item_o.flag   = flag_i;
    item_o.sample = sample_i;
    item_o.last   = last_i;
    // saturate the pop length
    item_o.cnt    = (out_count_i > CountW'(PopLimit)) ? CountW'(PopLimit) : out_count_i;
    item_o.op     = OP_PUSH;
    keep_o        = 1'b1;
    unique case (kind_i)
      KIND_PUSH:  item_o.op = OP_PUSH;
      KIND_POP:   item_o.op = OP_POP;
      KIND_CLEAR: item_o.op = OP_CLEAR;
      default:    keep_o    = 1'b0;   // drop unknown kinds here
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ajb_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none
module ajb_queue
  import ajb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  item_t      wr_item_i,
  output logic       not_full_o,
  input  wire logic  rd_i,
  output item_t      rd_item_o,
  output logic       not_empty_o
);

  localparam int unsigned Depth = 2;

  item_t       mem_q [Depth];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;

  assign not_full_o  = (cnt_q != 2'(Depth));
  assign not_empty_o = (cnt_q != 2'd0);
  assign rd_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wr_i ? ~wp_q : wp_q;
    rp_d  = rd_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(wr_i) - 2'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ajb_back.sv =====
// Back end: staging, slot search, commit, eviction and playout.
`default_nettype none
module ajb_back
  import ajb_pkg::*;
#(
  parameter int unsigned MAX_FRAMES  = MaxFramesDefault,
  parameter int unsigned MAX_SAMPLES = MaxSamplesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [DepthW-1:0]  target_depth_i,
  input  wire logic               q_valid_i,
  input  item_t                   q_item_i,
  output logic                    q_pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [SampleW-1:0]      m_sample_o,
  output logic [FlagW-1:0]        m_flag_o,
  output logic                    m_hit_o,
  output logic                    m_last_o
);

  localparam int unsigned IW   = $clog2(MAX_FRAMES);
  localparam int unsigned KW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned LW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SAW  = $clog2(MAX_FRAMES * MAX_SAMPLES);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned MW   = LW + FlagW + SeqW;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_SCAN_END = 4'd2;
  localparam logic [3:0] ST_COPY     = 4'd3;
  localparam logic [3:0] ST_TRIM     = 4'd4;
  localparam logic [3:0] ST_EMIT_RD  = 4'd5;
  localparam logic [3:0] ST_EMIT_WR  = 4'd6;
  localparam logic [3:0] ST_POP_END  = 4'd7;

  localparam logic [1:0] MD_COMMIT = 2'd0;
  localparam logic [1:0] MD_EVICT  = 2'd1;
  localparam logic [1:0] MD_POP    = 2'd2;

  // memories
  logic [MW-1:0]      meta_mem  [MAX_FRAMES];
  logic [SampleW-1:0] stage_mem [MAX_SAMPLES];
  logic [SampleW-1:0] smp_mem   [MAX_FRAMES * MAX_SAMPLES];

  logic               meta_we;
  logic [IW-1:0]      meta_wa, meta_ra;
  logic [MW-1:0]      meta_wd, meta_rd_q;
  logic               stage_we;
  logic [KW-1:0]      stage_wa, stage_ra;
  logic [SampleW-1:0] stage_wd, stage_rd_q;
  logic               smp_we;
  logic [SAW-1:0]     smp_wa, smp_ra;
  logic [SampleW-1:0] smp_wd, smp_rd_q;

  logic [3:0]         state_q, state_d;
  logic [1:0]         mode_q, mode_d;
  logic               started_q, started_d;
  logic [SeqW-1:0]    next_seq_q, next_seq_d;
  logic [MAX_FRAMES-1:0] used_q, used_d;
  logic [CW-1:0]      nused_q, nused_d;
  logic [LW-1:0]      stg_q, stg_d;
  logic [SeqW-1:0]    key_q, key_d;
  logic [FlagW-1:0]   flag_q, flag_d;
  logic [CountW-1:0]  pcnt_q, pcnt_d;
  logic [IW:0]        sj_q, sj_d;
  logic               pend_q, pend_d;
  logic [IW-1:0]      ev_idx_q, ev_idx_d;
  logic               fnd_vld_q, fnd_vld_d;
  logic [IW-1:0]      fnd_idx_q, fnd_idx_d;
  logic [FlagW-1:0]   fnd_flag_q, fnd_flag_d;
  logic [LW-1:0]      fnd_len_q, fnd_len_d;
  logic               min_vld_q, min_vld_d;
  logic [IW-1:0]      min_idx_q, min_idx_d;
  logic [SeqW-1:0]    min_seq_q, min_seq_d;
  logic               free_vld_q, free_vld_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic [IW-1:0]      slot_q, slot_d;
  logic [LW-1:0]      ck_q, ck_d;
  logic               cpend_q, cpend_d;
  logic               src_q, src_d;
  logic [CountW-1:0]  ek_q, ek_d;
  logic               m_vld_q, m_vld_d;
  logic [SampleW-1:0] m_smp_q, m_smp_d;
  logic [FlagW-1:0]   m_flag_q, m_flag_d;
  logic               m_hit_q, m_hit_d;
  logic               m_last_q, m_last_d;

  logic [CMPW-1:0]    cap4, cap;
  logic [SeqW-1:0]    ns_eff, seq_gap, ev_seq;
  logic [LW-1:0]      stg_inc;
  logic               ev_hit;

  assign cap4 = CMPW'({target_depth_i, 2'b00});
  assign cap  = (cap4 > CMPW'(MAX_FRAMES)) ? CMPW'(MAX_FRAMES) : cap4;
  assign ev_seq = meta_rd_q[SeqW-1:0];
  assign ev_hit = pend_q && used_q[ev_idx_q];

  assign m_valid_o  = m_vld_q;
  assign m_sample_o = m_smp_q;
  assign m_flag_o   = m_flag_q;
  assign m_hit_o    = m_hit_q;
  assign m_last_o   = m_last_q;

  always_comb begin
    state_d    = state_q;    mode_d     = mode_q;
    started_d  = started_q;  next_seq_d = next_seq_q;
    used_d     = used_q;     nused_d    = nused_q;
    stg_d      = stg_q;      key_d      = key_q;
    flag_d     = flag_q;     pcnt_d     = pcnt_q;
    sj_d       = sj_q;       pend_d     = 1'b0;
    ev_idx_d   = ev_idx_q;
    fnd_vld_d  = fnd_vld_q;  fnd_idx_d  = fnd_idx_q;
    fnd_flag_d = fnd_flag_q; fnd_len_d  = fnd_len_q;
    min_vld_d  = min_vld_q;  min_idx_d  = min_idx_q;  min_seq_d = min_seq_q;
    free_vld_d = free_vld_q; free_idx_d = free_idx_q;
    slot_d     = slot_q;     ck_d       = ck_q;       cpend_d   = 1'b0;
    src_d      = src_q;      ek_d       = ek_q;
    m_vld_d    = m_vld_q && !m_ready_i;
    m_smp_d    = m_smp_q;    m_flag_d   = m_flag_q;
    m_hit_d    = m_hit_q;    m_last_d   = m_last_q;
    q_pop_o    = 1'b0;
    meta_we    = 1'b0;  meta_wa = slot_q;  meta_wd = {stg_q, flag_q, key_q};
    meta_ra    = sj_q[IW-1:0];
    stage_we   = 1'b0;  stage_wa = stg_q[KW-1:0];  stage_wd = q_item_i.sample;
    stage_ra   = ck_q[KW-1:0];
    smp_we     = 1'b0;
    smp_wa     = SAW'(slot_q) * SAW'(MAX_SAMPLES) + SAW'(ck_q - LW'(1));
    smp_wd     = stage_rd_q;
    smp_ra     = SAW'(fnd_idx_q) * SAW'(MAX_SAMPLES) + SAW'(ek_q);
    ns_eff     = started_q ? next_seq_q : q_item_i.seq;
    seq_gap    = q_item_i.seq - ns_eff;
    stg_inc    = stg_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.op)
            OP_PUSH: begin
              started_d  = 1'b1;
              next_seq_d = ns_eff;
              if (stg_q < LW'(MAX_SAMPLES)) begin
                stage_we = 1'b1;
                stg_inc  = stg_q + LW'(1);
              end
              stg_d  = stg_inc;
              key_d  = q_item_i.seq;
              flag_d = q_item_i.flag;
              if (q_item_i.last) begin
                if (seq_gap[SeqW-1]) begin
                  stg_d = '0;          // behind playout: drop the frame
                end else begin
                  mode_d     = MD_COMMIT;
                  state_d    = ST_SCAN;
                  sj_d       = '0;
                  fnd_vld_d  = 1'b0;
                  min_vld_d  = 1'b0;
                  free_vld_d = 1'b0;
                end
              end
            end
            OP_POP: begin
              pcnt_d = q_item_i.cnt;
              ek_d   = '0;
              key_d  = next_seq_q;
              if (started_q && nused_q != '0) begin
                mode_d     = MD_POP;
                state_d    = ST_SCAN;
                sj_d       = '0;
                fnd_vld_d  = 1'b0;
                min_vld_d  = 1'b0;
                free_vld_d = 1'b0;
              end else begin
                src_d   = 1'b0;
                state_d = (q_item_i.cnt != '0) ? ST_EMIT_RD : ST_POP_END;
              end
            end
            OP_CLEAR: begin
              used_d     = '0;
              nused_d    = '0;
              next_seq_d = '0;
              started_d  = 1'b0;
              stg_d      = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // issue one slot read per cycle, evaluate the one read last cycle
        if (sj_q < (IW+1)'(MAX_FRAMES)) begin
          pend_d   = 1'b1;
          ev_idx_d = sj_q[IW-1:0];
          sj_d     = sj_q + (IW+1)'(1);
        end else begin
          state_d = ST_SCAN_END;
        end
        if (ev_hit) begin
          if (!fnd_vld_q && ev_seq == key_q) begin
            fnd_vld_d  = 1'b1;
            fnd_idx_d  = ev_idx_q;
            fnd_flag_d = meta_rd_q[SeqW +: FlagW];
            fnd_len_d  = meta_rd_q[SeqW+FlagW +: LW];
          end
          if (!min_vld_q || ev_seq < min_seq_q) begin
            min_vld_d = 1'b1;
            min_idx_d = ev_idx_q;
            min_seq_d = ev_seq;
          end
        end else if (pend_q && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = ev_idx_q;
        end
      end

      ST_SCAN_END: begin
        unique case (mode_q)
          MD_COMMIT: begin
            state_d = ST_COPY;
            ck_d    = '0;
            if (fnd_vld_q) begin
              slot_d = fnd_idx_q;
            end else if (nused_q >= CW'(MAX_FRAMES)) begin
              if (key_q < min_seq_q) begin
                state_d = ST_IDLE;     // smaller than everything stored
                stg_d   = '0;
              end else begin
                slot_d = min_idx_q;    // replace the smallest in place
              end
            end else begin
              slot_d            = free_idx_q;
              used_d[free_idx_q] = 1'b1;
              nused_d           = nused_q + CW'(1);
            end
            meta_wa = slot_d;
            meta_we = (state_d == ST_COPY);
          end
          MD_EVICT: begin
            if (min_vld_q) begin
              used_d[min_idx_q] = 1'b0;
              nused_d           = nused_q - CW'(1);
              state_d           = ST_TRIM;
            end else begin
              stg_d   = '0;
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (CMPW'(nused_q) < CMPW'(target_depth_i) && min_seq_q == next_seq_q) begin
              src_d = 1'b0;            // still filling: hold playout
            end else begin
              src_d      = fnd_vld_q;
              next_seq_d = next_seq_q + SeqW'(1);
            end
            state_d = (pcnt_q != '0) ? ST_EMIT_RD : ST_POP_END;
          end
        endcase
      end

      ST_COPY: begin
        if (ck_q < stg_q) begin
          cpend_d = 1'b1;
          ck_d    = ck_q + LW'(1);
        end else begin
          state_d = ST_TRIM;
        end
        smp_we = cpend_q;
      end

      ST_TRIM: begin
        if (CMPW'(nused_q) > cap) begin
          mode_d     = MD_EVICT;
          state_d    = ST_SCAN;
          sj_d       = '0;
          fnd_vld_d  = 1'b0;
          min_vld_d  = 1'b0;
          free_vld_d = 1'b0;
        end else begin
          stg_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end

      ST_EMIT_WR: begin
        if (!m_vld_q || m_ready_i) begin
          m_vld_d  = 1'b1;
          m_smp_d  = (src_q && CountW'(ek_q) < CountW'(fnd_len_q)) ? smp_rd_q : '0;
          m_flag_d = src_q ? fnd_flag_q : '0;
          m_hit_d  = src_q;
          m_last_d = (ek_q + CountW'(1) == pcnt_q);
          ek_d     = ek_q + CountW'(1);
          state_d  = (ek_q + CountW'(1) == pcnt_q) ? ST_POP_END : ST_EMIT_RD;
        end
      end

      ST_POP_END: begin
        if (src_q) begin
          used_d[fnd_idx_q] = 1'b0;
          nused_d           = nused_q - CW'(1);
        end
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stage_we) begin
      stage_mem[stage_wa] <= stage_wd;
    end
    stage_rd_q <= stage_mem[stage_ra];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[smp_wa] <= smp_wd;
    end
    smp_rd_q <= smp_mem[smp_ra];
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;      flag_q     <= flag_d;     pcnt_q    <= pcnt_d;
    ev_idx_q   <= ev_idx_d;
    fnd_idx_q  <= fnd_idx_d;  fnd_flag_q <= fnd_flag_d; fnd_len_q <= fnd_len_d;
    min_idx_q  <= min_idx_d;  min_seq_q  <= min_seq_d;  free_idx_q <= free_idx_d;
    slot_q     <= slot_d;
    m_smp_q    <= m_smp_d;    m_flag_q   <= m_flag_d;
    m_hit_q    <= m_hit_d;    m_last_q   <= m_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MD_COMMIT;
      started_q  <= 1'b0;
      next_seq_q <= '0;
      used_q     <= '0;
      nused_q    <= '0;
      stg_q      <= '0;
      sj_q       <= '0;
      pend_q     <= 1'b0;
      fnd_vld_q  <= 1'b0;
      min_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      ck_q       <= '0;
      cpend_q    <= 1'b0;
      src_q      <= 1'b0;
      ek_q       <= '0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      started_q  <= started_d;
      next_seq_q <= next_seq_d;
      used_q     <= used_d;
      nused_q    <= nused_d;
      stg_q      <= stg_d;
      sj_q       <= sj_d;
      pend_q     <= pend_d;
      fnd_vld_q  <= fnd_vld_d;
      min_vld_q  <= min_vld_d;
      free_vld_q <= free_vld_d;
      ck_q       <= ck_d;
      cpend_q    <= cpend_d;
      src_q      <= src_d;
      ek_q       <= ek_d;
      m_vld_q    <= m_vld_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/audio_jitter_buffer.sv =====
// Top level of the audio jitter buffer: config register, front end, queue, back end.
//
//  channel   direction  signals                                  transfer when
//  s_axis    in         tdata/tuser/tlast (push, pop, clear)     s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata/tuser/tlast (one played sample)    m_axis_tvalid & m_axis_tready
//  apb       in         psel/penable/pwrite/paddr/pwdata/prdata  psel & penable & pwrite & pready
//
// A push sample is only staged unless it ends a frame; a frame end costs one
// slot scan, a copy of its samples and one further scan per evicted frame.
// A pop with a started, non-empty buffer costs one scan, then a read state
// and a write state per emitted sample; the single slot scan over the slot
// table and the one sample memory port set these costs.
// Reset is asynchronous, active low; memories are not cleared, only the slot
// valid bits. The two-entry queue keeps input flowing while the back end
// works, and a full output register holds the back end until it is taken.
`default_nettype none
module audio_jitter_buffer
  import ajb_pkg::*;
#(
  parameter int unsigned MAX_FRAMES  = MaxFramesDefault,
  parameter int unsigned MAX_SAMPLES = MaxSamplesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [15:0] seq, [23:16] flag, [39:24] sample, [46:40] out_count, [47] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] out_sample, [23:16] out_flag
  output logic [23:0]      m_axis_tdata,
  // [0] hit
  output logic [0:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [DepthW-1:0] td_q;
  item_t             fr_item, q_item;
  logic              fr_keep, q_not_full, q_not_empty, q_pop, s_take;
  logic [SampleW-1:0] o_smp;
  logic [FlagW-1:0]   o_flag;

  // configuration port: zero wait states, single register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_DEPTH) ? 32'(td_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      td_q <= DepthReset;
    end else if (psel && penable && pwrite && paddr[2] == REG_TARGET_DEPTH) begin
      td_q <= pwdata[DepthW-1:0];
    end
  end

  // accept while the queue has room; unknown kinds are taken and dropped
  assign s_axis_tready = q_not_full;
  assign s_take        = s_axis_tvalid && q_not_full && fr_keep;

  ajb_front u_front (
    .kind_i      (s_axis_tuser),
    .seq_i       (s_axis_tdata[15:0]),
    .flag_i      (s_axis_tdata[23:16]),
    .sample_i    (s_axis_tdata[39:24]),
    .last_i      (s_axis_tlast),
    .out_count_i (s_axis_tdata[46:40]),
    .item_o      (fr_item),
    .keep_o      (fr_keep)
  );

  ajb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (s_take),
    .wr_item_i   (fr_item),
    .not_full_o  (q_not_full),
    .rd_i        (q_pop),
    .rd_item_o   (q_item),
    .not_empty_o (q_not_empty)
  );

  ajb_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .target_depth_i (td_q),
    .q_valid_i      (q_not_empty),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_sample_o     (o_smp),
    .m_flag_o       (o_flag),
    .m_hit_o        (m_axis_tuser[0]),
    .m_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {o_flag, o_smp};

endmodule
`default_nettype wire
